[design/gnd_pkg.sv]
// ----------------------------------------------------------------------------
// gnd_pkg
// Shared types, constants and constant tables of the note dispenser: request
// and result beats, the job passed from front end to back end, and the
// reciprocal tables for the greedy division steps.
// ----------------------------------------------------------------------------
package gnd_pkg;

    // note count storage width
    localparam int COUNT_WIDTH = 16;

    localparam int NOTE_KINDS  = 4;
    localparam int IDX_W       = $clog2(NOTE_KINDS);
    localparam int AMT_W       = 28;
    localparam int ADD_W       = 16;
    localparam int PLAN_W      = 16;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    // amounts in hundreds: 2^28 / 100 fits in 22 bits
    localparam int REST_W      = 22;

    // note index order: largest face first
    localparam logic [IDX_W-1:0] NOTE_2000 = IDX_W'(0);
    localparam logic [IDX_W-1:0] NOTE_500  = IDX_W'(1);
    localparam logic [IDX_W-1:0] NOTE_200  = IDX_W'(2);
    localparam logic [IDX_W-1:0] NOTE_100  = IDX_W'(3);
    localparam logic [IDX_W-1:0] LAST_NOTE = IDX_W'(NOTE_KINDS - 1);

    // face values, full and in hundreds
    localparam int FACE_W      = 11;
    localparam int FACE_H_W    = 5;
    localparam logic [6:0] NOTE_UNIT = 7'd100;

    // exact division by 100 of a 28-bit amount: (x * m) >> 35
    localparam int DIV100_MUL_W = 29;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 29'd343597384;
    localparam int DIV100_SHIFT = 35;
    localparam int DIV100_PROD_W = AMT_W + DIV100_MUL_W;

    // exact division of a 22-bit rest by the face in hundreds
    localparam int RECIP_W     = 23;
    localparam int RECIP_PROD_W = REST_W + RECIP_W;
    localparam int SHIFT_W     = 5;

    // widths for compares and sums that mix counts and rests
    localparam int CMP_W  = (REST_W > COUNT_WIDTH) ? REST_W : COUNT_WIDTH;
    localparam int SAT_W  = ((COUNT_WIDTH > ADD_W) ? COUNT_WIDTH : ADD_W) + 1;
    localparam int TAKE_PROD_W = COUNT_WIDTH + FACE_H_W;
    localparam int ACC_W  = (COUNT_WIDTH + FACE_W + 2 > AMT_W + 1) ?
                            (COUNT_WIDTH + FACE_W + 2) : (AMT_W + 1);

    localparam logic [AMT_W-1:0]       TOTAL_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // hand-off queue
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_DISPENSE = 2'd0,
        OP_QUERY    = 2'd1,
        OP_REFILL   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOT_MULT = 2'd1,
        ST_EXCEEDS  = 2'd2,
        ST_NO_COMBO = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_CHECK
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_TAKE,
        B_CHECK,
        B_UPDATE,
        B_SUM,
        B_EMIT
    } t_back_state;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [AMT_W-1:0] amount;
        logic [ADD_W-1:0] add_hundreds;
        logic [ADD_W-1:0] add_two_hundreds;
        logic [ADD_W-1:0] add_five_hundreds;
        logic [ADD_W-1:0] add_two_thousands;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PLAN_W-1:0]   out_two_thousands;
        logic [PLAN_W-1:0]   out_five_hundreds;
        logic [PLAN_W-1:0]   out_two_hundreds;
        logic [PLAN_W-1:0]   out_hundreds;
        logic [AMT_W-1:0]    cash_total;
    } t_res;

    // classified request, front end to back end
    typedef struct packed {
        logic [OP_W-1:0]                  op;
        t_status                          status;
        logic [REST_W-1:0]                rest;
        logic [NOTE_KINDS-1:0][ADD_W-1:0] adds;
    } t_job;

    function automatic logic [FACE_W-1:0] note_face(input logic [IDX_W-1:0] idx);
        logic [FACE_W-1:0] face;
        unique case (idx)
            NOTE_2000: face = 11'd2000;
            NOTE_500:  face = 11'd500;
            NOTE_200:  face = 11'd200;
            default:   face = 11'd100;
        endcase
        return face;
    endfunction

    function automatic logic [FACE_H_W-1:0] note_face_h(input logic [IDX_W-1:0] idx);
        logic [FACE_H_W-1:0] face;
        unique case (idx)
            NOTE_2000: face = 5'd20;
            NOTE_500:  face = 5'd5;
            NOTE_200:  face = 5'd2;
            default:   face = 5'd1;
        endcase
        return face;
    endfunction

    // reciprocal multiplier, exact for every 22-bit rest
    function automatic logic [RECIP_W-1:0] note_recip(input logic [IDX_W-1:0] idx);
        logic [RECIP_W-1:0] m;
        unique case (idx)
            NOTE_2000: m = 23'd6710887;
            NOTE_500:  m = 23'd6710887;
            NOTE_200:  m = 23'd4194305;
            default:   m = 23'd4194305;
        endcase
        return m;
    endfunction

    function automatic logic [SHIFT_W-1:0] note_shift(input logic [IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] s;
        unique case (idx)
            NOTE_2000: s = 5'd27;
            NOTE_500:  s = 5'd25;
            NOTE_200:  s = 5'd23;
            default:   s = 5'd22;
        endcase
        return s;
    endfunction

endpackage

[design/gnd_front.sv]
// ----------------------------------------------------------------------------
// gnd_front
// Front end: captures a request beat, converts the amount to hundreds,
// checks the multiple-of-100 and total-cash rules and queues a job.
// ----------------------------------------------------------------------------
module gnd_front
    import gnd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_req              i_req,
    input  logic [AMT_W-1:0]  i_total,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job,
    output logic              o_busy
);

    t_front_state r_state, n_state;

    logic [OP_W-1:0]                  r_op;
    logic [AMT_W-1:0]                 r_amount;
    logic [NOTE_KINDS-1:0][ADD_W-1:0] r_adds;
    logic [REST_W-1:0]                r_quot;

    logic [DIV100_PROD_W-1:0] quot_prod;
    logic [AMT_W-1:0]         back_prod;
    logic                     not_mult;
    logic                     is_request;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_accept) n_state = F_DIV;
            F_DIV:   n_state = F_CHECK;
            F_CHECK: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy = (r_state != F_IDLE);
        o_push = (r_state == F_CHECK) && !i_full;
    end

    // request capture and quotient by 100
    assign quot_prod = DIV100_PROD_W'(r_amount) * DIV100_PROD_W'(DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_state == F_IDLE)) begin
            r_op              <= i_req.operation;
            r_amount          <= i_req.amount;
            r_adds[NOTE_2000] <= i_req.add_two_thousands;
            r_adds[NOTE_500]  <= i_req.add_five_hundreds;
            r_adds[NOTE_200]  <= i_req.add_two_hundreds;
            r_adds[NOTE_100]  <= i_req.add_hundreds;
        end
        if (r_state == F_DIV) begin
            r_quot <= REST_W'(quot_prod >> DIV100_SHIFT);
        end
    end

    // classification
    assign back_prod  = AMT_W'(r_quot) * AMT_W'(NOTE_UNIT);
    assign not_mult   = (back_prod != r_amount);
    assign is_request = (r_op == OP_DISPENSE) || (r_op == OP_QUERY);

    always_comb begin
        o_job.op   = r_op;
        o_job.rest = r_quot;
        o_job.adds = r_adds;
        if (is_request && not_mult) begin
            o_job.status = ST_NOT_MULT;
        end else if (is_request && (r_amount > i_total)) begin
            o_job.status = ST_EXCEEDS;
        end else begin
            o_job.status = ST_OK;
        end
    end

endmodule

[design/gnd_queue.sv]
// ----------------------------------------------------------------------------
// gnd_queue
// Small job queue between front end and back end.
// ----------------------------------------------------------------------------
module gnd_queue
    import gnd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job               r_slot [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from empty queue");

endmodule

[design/gnd_back.sv]
// ----------------------------------------------------------------------------
// gnd_back
// Back end: holds the note stock and cash total, builds the greedy plan one
// denomination at a time on a shared reciprocal multiplier, applies
// dispense or refill, re-totals the stock and issues the result beat.
// ----------------------------------------------------------------------------
module gnd_back
    import gnd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_job              i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_done,
    output t_res              o_res,
    output logic [AMT_W-1:0]  o_total
);

    t_back_state r_state, n_state;

    logic [COUNT_WIDTH-1:0]           r_stock [NOTE_KINDS];
    logic [AMT_W-1:0]                 r_total;
    logic [COUNT_WIDTH-1:0]           r_plan  [NOTE_KINDS];
    logic [OP_W-1:0]                  r_op;
    t_status                          r_status;
    logic [REST_W-1:0]                r_rest;
    logic [REST_W-1:0]                r_want;
    logic [NOTE_KINDS-1:0][ADD_W-1:0] r_adds;
    logic [IDX_W-1:0]                 r_idx;
    logic [ACC_W-1:0]                 r_acc;

    logic [COUNT_WIDTH-1:0]  stock_rd;
    logic [RECIP_PROD_W-1:0] div_prod;
    logic [COUNT_WIDTH-1:0]  take;
    logic [TAKE_PROD_W-1:0]  take_prod;
    logic [ACC_W-1:0]        acc_next;
    logic                    job_plans;

    assign stock_rd  = r_stock[r_idx];
    assign job_plans = ((i_job.op == OP_DISPENSE) || (i_job.op == OP_QUERY))
                       && (i_job.status == ST_OK);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_job.op == OP_REFILL) n_state = B_UPDATE;
                    else if (job_plans)        n_state = B_DIV;
                    else                       n_state = B_EMIT;
                end
            end
            B_DIV:  n_state = B_TAKE;
            B_TAKE: n_state = (r_idx == LAST_NOTE) ? B_CHECK : B_DIV;
            B_CHECK: begin
                if (r_rest != '0)              n_state = B_EMIT;
                else if (r_op == OP_DISPENSE)  n_state = B_UPDATE;
                else                           n_state = B_EMIT;
            end
            B_UPDATE: n_state = B_SUM;
            B_SUM:    n_state = (r_idx == LAST_NOTE) ? B_EMIT : B_SUM;
            B_EMIT:   n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop  = (r_state == B_IDLE) && !i_empty;
        o_busy = (r_state != B_IDLE);
        o_done = (r_state == B_EMIT);
    end

    // greedy step arithmetic
    assign div_prod = RECIP_PROD_W'(r_rest) * RECIP_PROD_W'(note_recip(r_idx));

    always_comb begin
        if (CMP_W'(r_want) < CMP_W'(stock_rd)) begin
            take = COUNT_WIDTH'(r_want);
        end else begin
            take = stock_rd;
        end
    end

    assign take_prod = TAKE_PROD_W'(take) * TAKE_PROD_W'(note_face_h(r_idx));

    // re-total accumulation
    assign acc_next = r_acc + ACC_W'(ACC_W'(stock_rd) * ACC_W'(note_face(r_idx)));

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            unique case (r_state)
                B_IDLE:   r_idx <= '0;
                B_TAKE:   r_idx <= r_idx + 1'b1;
                B_UPDATE: r_idx <= '0;
                B_SUM:    r_idx <= r_idx + 1'b1;
                default:  r_idx <= r_idx;
            endcase
        end
    end

    // stock and cash total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NOTE_KINDS; i++) r_stock[i] <= '0;
            r_total <= '0;
        end else begin
            if (r_state == B_UPDATE) begin
                for (int i = 0; i < NOTE_KINDS; i++) begin
                    logic [SAT_W-1:0] sum;
                    sum = SAT_W'(r_stock[i]) + SAT_W'(r_adds[i]);
                    if (r_op == OP_REFILL) begin
                        r_stock[i] <= (sum > SAT_W'(COUNT_MAX)) ? COUNT_MAX
                                                                : COUNT_WIDTH'(sum);
                    end else begin
                        r_stock[i] <= r_stock[i] - r_plan[i];
                    end
                end
            end
            if ((r_state == B_SUM) && (r_idx == LAST_NOTE)) begin
                r_total <= (acc_next > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : AMT_W'(acc_next);
            end
        end
    end

    // job and plan registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_op     <= i_job.op;
                r_status <= i_job.status;
                r_rest   <= i_job.rest;
                r_adds   <= i_job.adds;
                for (int i = 0; i < NOTE_KINDS; i++) r_plan[i] <= '0;
            end
            B_DIV: begin
                r_want <= REST_W'(div_prod >> note_shift(r_idx));
            end
            B_TAKE: begin
                r_plan[r_idx] <= take;
                r_rest        <= r_rest - REST_W'(take_prod);
            end
            B_CHECK: begin
                if (r_rest != '0) begin
                    r_status <= ST_NO_COMBO;
                    for (int i = 0; i < NOTE_KINDS; i++) r_plan[i] <= '0;
                end
            end
            B_UPDATE: begin
                r_acc <= '0;
            end
            B_SUM: begin
                r_acc <= acc_next;
            end
            default: begin
                r_rest <= r_rest;
            end
        endcase
    end

    // result beat
    always_comb begin
        o_res.status            = r_status;
        o_res.out_two_thousands = PLAN_W'(r_plan[NOTE_2000]);
        o_res.out_five_hundreds = PLAN_W'(r_plan[NOTE_500]);
        o_res.out_two_hundreds  = PLAN_W'(r_plan[NOTE_200]);
        o_res.out_hundreds      = PLAN_W'(r_plan[NOTE_100]);
        o_res.cash_total        = r_total;
    end

    assign o_total = r_total;

    a_rest_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TAKE) |=> (r_rest <= $past(r_rest)))
        else $error("greedy rest grew after a take step");

    a_leftover_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHECK && r_rest != '0) |=>
            (r_state == B_EMIT && r_status == ST_NO_COMBO))
        else $error("leftover rest not reported as failure");

endmodule

[design/greedy_note_dispenser.sv]
// ----------------------------------------------------------------------------
// greedy_note_dispenser
// Cash box with notes of 2000, 500, 200 and 100: dispense, query and refill
// requests against a greedy, stock-limited plan.
// ----------------------------------------------------------------------------
// One request is handled at a time: busy rises on the cycle after start is
// taken and falls after the result beat. The result strobe o_done is high for
// one cycle and cannot be held off. After the front end's divide and check
// states and the queue, a request failing the multiple-of-100 or total check
// or with an unused code goes to the beat; a refill updates and re-totals
// the stock; a query runs the greedy plan, a divide and a take step per
// denomination on the single reciprocal multiplier; a successful dispense
// runs the plan, then updates and re-totals the stock, one denomination per
// cycle. A new request can be taken in the cycle after the beat.
// ----------------------------------------------------------------------------
module greedy_note_dispenser
    import gnd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    logic             accept;
    logic             front_busy;
    logic             back_busy;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    t_job             front_job;
    t_job             back_job;
    logic [AMT_W-1:0] total;

    // request beat taken only when nothing is in flight
    assign accept = start && !busy;
    assign busy   = front_busy || !q_empty || back_busy;

    gnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_req   (i_req),
        .i_total (total),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (front_job),
        .o_busy  (front_busy)
    );

    gnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (back_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gnd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (back_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_busy  (back_busy),
        .o_done  (o_done),
        .o_res   (o_res),
        .o_total (total)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request beat taken but block not busy");

endmodule
